/* src/fsw_pkg.sv */
// Shared constants, register indexes and the sine-table generator for the
// Fourier series evaluator. No dependencies.
`default_nettype none
package fsw_pkg;

	// Default sizes handed to the top level
	localparam int DEF_MAX_HARMONICS   = 63;
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int DEF_GRID_INDEX_BITS = 16;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_HARMONIC_COUNT  = 2'd0,
		CFG_PHASE_STEP      = 2'd1,
		CFG_BASE_WAVENUMBER = 2'd2
	} cfg_reg_t;

	localparam logic [31:0] BASE_WAVENUMBER_RESET = 32'd65536;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	// Evaluation item kinds
	localparam logic KIND_LOAD = 1'b0;

	// Quarter-wave sine magnitude, Q1.30, truncating Taylor series to theta^15
	function automatic logic [30:0] quarter_sine(input int r, input int sb);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic signed [63:0] sum;
		th   = (64'(r) * TWO_PI_Q30) >> sb;
		th2  = (th * th) >> 30;
		term = th;
		sum  = $signed(th);
		term = ((term * th2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * th2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * th2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * th2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * th2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * th2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * th2) >> 30) / 64'd210; sum = sum - $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > 64'sd1073741824) begin
			sum = 64'sd1073741824;
		end
		return sum[30:0];
	endfunction

endpackage
`default_nettype wire

/* src/fsw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module fsw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 127,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* src/fsw_mul.sv */
// Multi-cycle 64x64 unsigned multiplier built from one 32x32 multiplier;
// four partial products accumulate into a 128-bit result. No dependencies.
`default_nettype none
module fsw_mul (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  op_a,
	input  wire logic [63:0]  op_b,
	output logic              done,
	output logic      [127:0] prod
);

	logic [63:0]  a_q, b_q, pp_q;
	logic [2:0]   cnt_q;
	logic [1:0]   sh_q;
	logic         busy_q, pv_q, done_q;
	logic [127:0] acc_q, pp_ext;
	logic [31:0]  a_half, b_half;

	assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	// Place the pending partial product at its weight
	always_comb begin
		unique case (sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				pv_q   <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					pv_q  <= 1'b1;
					cnt_q <= cnt_q + 3'd1;
				end else begin
					pv_q   <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Issue one partial product a cycle, accumulate the previous one
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q <= a_half * b_half;
				sh_q <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
			end
			if (pv_q) begin
				acc_q <= acc_q + pp_ext;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

/* src/fourier_series_with_derivatives.sv */
// Fourier series evaluator with first three derivatives; uses fsw_pkg,
// fsw_ram (coefficient table) and fsw_mul (shared multiplier).
// Load transaction: written to the coefficient table on acceptance. Evaluate
// transaction: the result becomes valid in the same cycle that the input is ready
// again; for N summed harmonics, each harmonic takes nine passes through the
// shared multiplier plus table reads and accumulation.
// A full output register holds the final state and stalls the input.
// Reset clears configuration and control; the coefficient table is undefined.
`default_nettype none
module fourier_series_with_derivatives
	import fsw_pkg::*;
#(
	parameter int MAX_HARMONICS   = DEF_MAX_HARMONICS,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
	parameter int GRID_INDEX_BITS = DEF_GRID_INDEX_BITS,
	localparam int IN_W  = 39 + GRID_INDEX_BITS,
	localparam int IN_TW = ((IN_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// coef_index[6:0], coef_value[38:7], grid_index above, zero pad
	input  wire logic [IN_TW-1:0] s_tdata,
	// kind
	input  wire logic             s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// field_value, first_derivative, second_derivative, third_derivative
	output logic      [191:0]     m_tdata,
	// saturated
	output logic                  m_tuser,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data
);

	localparam int DEPTH   = 2 * MAX_HARMONICS + 1;
	localparam int AW      = $clog2(DEPTH);
	localparam int HB      = $clog2(MAX_HARMONICS + 1);
	localparam int KW      = 32 + HB;
	localparam int SB      = SINE_TABLE_BITS;
	localparam int QB      = SB - 2;
	localparam int QUARTER = 1 << QB;

	localparam logic signed [47:0] OUT_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] OUT_MIN = {1'b1, {47{1'b0}}};

	typedef logic [30:0] qt_t [QUARTER+1];

	function automatic qt_t build_qt();
		qt_t t;
		for (int i = 0; i <= QUARTER; i++) begin
			t[i] = quarter_sine(i, SB);
		end
		return t;
	endfunction

	localparam qt_t QT = build_qt();

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_PH   = 11'b00000000010,
		ST_F0   = 11'b00000000100,
		ST_RDA  = 11'b00000001000,
		ST_RDB  = 11'b00000010000,
		ST_CAP  = 11'b00000100000,
		ST_GO   = 11'b00001000000,
		ST_WAIT = 11'b00010000000,
		ST_UV   = 11'b00100000000,
		ST_ACC  = 11'b01000000000,
		ST_FIN  = 11'b10000000000
	} state_t;

	typedef enum logic [3:0] {
		OP_AC, OP_BS, OP_AS, OP_BC, OP_K2, OP_K3, OP_T1, OP_T2, OP_T3
	} op_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	function automatic logic signed [33:0] to_q16(input logic signed [63:0] x);
		logic [63:0] m;
		logic [33:0] r;
		m = x[63] ? 64'(-x) : 64'(x);
		r = 34'(m >> 30);
		return x[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [48:0] sat_add(input logic signed [47:0] acc,
			input logic signed [63:0] t);
		logic signed [64:0] s;
		s = 65'(acc) + 65'(t);
		if (s > 65'(OUT_MAX)) begin
			return {1'b1, OUT_MAX};
		end
		if (s < 65'(OUT_MIN)) begin
			return {1'b1, OUT_MIN};
		end
		return {1'b0, s[47:0]};
	endfunction

	// Configuration and control registers
	state_t state_q, state_d;
	op_t    op_q;
	logic [5:0]  hc_q;
	logic [31:0] ps_q, base_q;
	logic        out_v_q;

	// Datapath registers
	logic [31:0] m_q, phase_q, ph_q;
	logic [HB-1:0] n_q, nmax_q;
	logic [KW-1:0] k1_q;
	logic [61:0] k2_q, k3_q;
	logic        c2_q, c3_q, sat_q;
	logic signed [31:0] a_q, b_q, s_q, c_q, rom_q;
	logic signed [63:0] p_ac_q, p_bs_q, p_as_q, p_bc_q, d1_q, d2_q, d3_q;
	logic signed [33:0] u_q, v_q;
	logic signed [47:0] f0_q, f1_q, f2_q, f3_q;
	logic [191:0] out_data_q;
	logic         out_sat_q;

	// Handshake and input fields
	logic in_acc, kind;
	logic [6:0] coef_index;
	logic [31:0] coef_value;
	logic [GRID_INDEX_BITS-1:0] grid_index;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign kind       = s_tuser;
	assign coef_index = s_tdata[6:0];
	assign coef_value = s_tdata[38:7];
	assign grid_index = s_tdata[39 +: GRID_INDEX_BITS];

	// Coefficient table
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	assign ram_we = in_acc && (kind == KIND_LOAD) && (32'(coef_index) < DEPTH);

	always_comb begin
		unique case (state_q)
			ST_RDA:  ram_raddr = AW'({n_q, 1'b0} - 1'b1);
			ST_RDB:  ram_raddr = AW'({n_q, 1'b0});
			default: ram_raddr = '0;
		endcase
	end

	fsw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(coef_index)),
		.wdata (coef_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sine table lookup, registered; cosine reads a quarter turn ahead
	logic [SB-1:0] rom_idx;
	logic [1:0]    quad;
	logic [QB:0]   qaddr;
	logic [31:0]   rom_mag;

	assign rom_idx = (state_q == ST_RDB) ? SB'(ph_q[31 -: SB] + SB'(QUARTER))
		: ph_q[31 -: SB];
	assign quad    = rom_idx[SB-1 -: 2];
	assign qaddr   = quad[0] ? (QB+1)'(QUARTER) - {1'b0, rom_idx[QB-1:0]}
		: {1'b0, rom_idx[QB-1:0]};
	assign rom_mag = {1'b0, QT[qaddr]};

	always_ff @(posedge clk) begin
		rom_q <= quad[1] ? -$signed(rom_mag) : $signed(rom_mag);
	end

	// Shared multiplier operand select
	logic [63:0]  mul_a, mul_b;
	logic         mul_done;
	logic [127:0] mul_prod;

	always_comb begin
		unique case (op_q)
			OP_AC: begin mul_a = 64'(mag32(a_q)); mul_b = 64'(mag32(c_q)); end
			OP_BS: begin mul_a = 64'(mag32(b_q)); mul_b = 64'(mag32(s_q)); end
			OP_AS: begin mul_a = 64'(mag32(a_q)); mul_b = 64'(mag32(s_q)); end
			OP_BC: begin mul_a = 64'(mag32(b_q)); mul_b = 64'(mag32(c_q)); end
			OP_K2: begin mul_a = 64'(k1_q); mul_b = 64'(k1_q); end
			OP_K3: begin mul_a = 64'(k2_q); mul_b = 64'(k1_q); end
			OP_T1: begin
				mul_a = 64'(v_q[33] ? 34'(-v_q) : 34'(v_q));
				mul_b = 64'(k1_q);
			end
			OP_T2: begin
				mul_a = 64'(u_q[33] ? 34'(-u_q) : 34'(u_q));
				mul_b = 64'(k2_q);
			end
			OP_T3: begin
				mul_a = 64'(v_q[33] ? 34'(-v_q) : 34'(v_q));
				mul_b = 64'(k3_q);
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	fsw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_GO),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Product post-processing: signed low word, or scaled and capped term
	logic        clip;
	logic [61:0] res;
	logic [63:0] pm;
	logic signed [63:0] res_s;

	assign clip  = |mul_prod[127:78];
	assign res   = clip ? {62{1'b1}} : mul_prod[77:16];
	assign res_s = $signed({2'b00, res});
	assign pm    = mul_prod[63:0];

	// Phase of the grid point, Q0.32 turns
	logic [32:0] t33;
	assign t33 = {m_q, 1'b0} - {1'b0, ps_q};

	// Saturating sums for the accumulate step, flag in the top bit
	logic [48:0] sum0, sum1, sum2, sum3;
	assign sum0 = sat_add(f0_q, 64'(u_q));
	assign sum1 = sat_add(f1_q, d1_q);
	assign sum2 = sat_add(f2_q, d2_q);
	assign sum3 = sat_add(f3_q, d3_q);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && kind != KIND_LOAD) begin
				state_d = ST_PH;
			end
			ST_PH:   state_d = ST_F0;
			ST_F0:   state_d = (nmax_q == '0) ? ST_FIN : ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_CAP;
			ST_CAP:  state_d = ST_GO;
			ST_GO:   state_d = ST_WAIT;
			ST_WAIT: if (mul_done) begin
				if (op_q == OP_BC) begin
					state_d = ST_UV;
				end else if (op_q == OP_T3) begin
					state_d = ST_ACC;
				end else begin
					state_d = ST_GO;
				end
			end
			ST_UV:   state_d = ST_GO;
			ST_ACC:  state_d = (n_q == nmax_q) ? ST_FIN : ST_RDA;
			ST_FIN:  if (!out_v_q || m_tready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hc_q    <= '0;
			ps_q    <= '0;
			base_q  <= BASE_WAVENUMBER_RESET;
			out_v_q <= 1'b0;
			op_q    <= OP_AC;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HARMONIC_COUNT:  hc_q   <= cfg_data[5:0];
					CFG_PHASE_STEP:      ps_q   <= cfg_data;
					CFG_BASE_WAVENUMBER: base_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FIN && (!out_v_q || m_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			// Advance the multiply sequence
			if (state_q == ST_CAP) begin
				op_q <= OP_AC;
			end else if (state_q == ST_WAIT && mul_done && op_q != OP_T3) begin
				op_q <= op_t'(op_q + 4'd1);
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				m_q    <= 32'(grid_index * ps_q);
				nmax_q <= (32'(hc_q) < MAX_HARMONICS) ? HB'(hc_q) : HB'(MAX_HARMONICS);
			end
			ST_PH: begin
				phase_q <= {~t33[32], t33[31:1]};
				ph_q    <= {~t33[32], t33[31:1]};
				k1_q    <= KW'(base_q);
				n_q     <= HB'(1);
				sat_q   <= 1'b0;
				f1_q    <= '0;
				f2_q    <= '0;
				f3_q    <= '0;
			end
			ST_F0: f0_q <= 48'($signed(ram_rdata));
			ST_RDB: begin
				a_q <= $signed(ram_rdata);
				s_q <= rom_q;
			end
			ST_CAP: begin
				b_q <= $signed(ram_rdata);
				c_q <= rom_q;
			end
			ST_WAIT: if (mul_done) begin
				unique case (op_q)
					OP_AC: p_ac_q <= (a_q[31] ^ c_q[31]) ? -$signed(pm) : $signed(pm);
					OP_BS: p_bs_q <= (b_q[31] ^ s_q[31]) ? -$signed(pm) : $signed(pm);
					OP_AS: p_as_q <= (a_q[31] ^ s_q[31]) ? -$signed(pm) : $signed(pm);
					OP_BC: p_bc_q <= (b_q[31] ^ c_q[31]) ? -$signed(pm) : $signed(pm);
					OP_K2: begin
						k2_q <= res;
						c2_q <= clip;
					end
					OP_K3: begin
						k3_q <= res;
						c3_q <= clip || c2_q;
					end
					OP_T1: begin
						d1_q  <= v_q[33] ? res_s : -res_s;
						sat_q <= sat_q || clip;
					end
					OP_T2: begin
						d2_q  <= u_q[33] ? res_s : -res_s;
						sat_q <= sat_q || ((u_q != '0) && (clip || c2_q));
					end
					OP_T3: begin
						d3_q  <= v_q[33] ? -res_s : res_s;
						sat_q <= sat_q || ((v_q != '0) && (clip || c3_q));
					end
					default: ;
				endcase
			end
			ST_UV: begin
				u_q <= to_q16(p_ac_q - p_bs_q);
				v_q <= to_q16(p_as_q + p_bc_q);
			end
			ST_ACC: begin
				f0_q  <= sum0[47:0];
				f1_q  <= sum1[47:0];
				f2_q  <= sum2[47:0];
				f3_q  <= sum3[47:0];
				sat_q <= sat_q || sum0[48] || sum1[48] || sum2[48] || sum3[48];
				n_q   <= n_q + HB'(1);
				ph_q  <= ph_q + phase_q;
				k1_q  <= k1_q + KW'(base_q);
			end
			ST_FIN: if (!out_v_q || m_tready) begin
				out_data_q <= {f3_q, f2_q, f1_q, f0_q};
				out_sat_q  <= sat_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the Fourier series evaluator with derivatives.
// Depends on fsw_pkg and fourier_series_with_derivatives; a built-in predictor
// computes the expected sums and a monitor compares every result transaction.
`default_nettype none
module tb
	import fsw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_EVAL = ~KIND_LOAD;
	localparam int HARM_LIMIT = 63;
	localparam int SLOTS = 2 * HARM_LIMIT + 1;
	localparam int SINE_N = 1024;
	localparam logic [63:0] TERM_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MAX = 64'sd140737488355327;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam int STALL_LIMIT = 60000;
	localparam int EXP_DEPTH = 16;

	typedef struct {
		logic signed [47:0] value;
		logic signed [47:0] d1;
		logic signed [47:0] d2;
		logic signed [47:0] d3;
		logic sat;
	} series_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [5:0] harm_count;
	logic [31:0] step_turns;
	logic [31:0] wavenumber;
	longint coef_table [SLOTS];
	longint sine_lut [SINE_N];
	series_t exp_fifo [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;

	int fail_count = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;
	int stall_asked = 0;
	int stall_served = 0;
	int hold_left = 0;

	fourier_series_with_derivatives dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Quarter-wave sine magnitude in Q1.30 from a truncated Taylor series
	function automatic longint sine_mag(input int r);
		logic [63:0] th, th2, term;
		longint acc;
		th = (64'(r) * TWO_PI_Q30) >> 10;
		th2 = (th * th) >> 30;
		term = th;
		acc = longint'(th);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sd1073741824) acc = 64'sd1073741824;
		return acc;
	endfunction

	// min(floor(a*b/2^16), cap), flag on clip
	function automatic logic [63:0] scale_mul(input logic [63:0] a, input logic [63:0] b,
			inout bit clip);
		logic [127:0] p;
		p = (128'(a) * 128'(b)) >> 16;
		if (p > 128'(TERM_CAP)) begin
			clip = 1'b1;
			return TERM_CAP;
		end
		return p[63:0];
	endfunction

	function automatic longint scaled(input longint x, input logic [63:0] k, input bit kclip,
			inout bit sat);
		logic [63:0] mag, m;
		bit c;
		c = 1'b0;
		if (x == 0) return 0;
		mag = x < 0 ? 64'(-x) : 64'(x);
		m = scale_mul(mag, k, c);
		if (c || kclip) sat = 1'b1;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat_add(input longint acc, input longint t, inout bit sat);
		longint s;
		s = acc + t;
		if (s > ACC_MAX) begin
			sat = 1'b1;
			return ACC_MAX;
		end
		if (s < ACC_MIN) begin
			sat = 1'b1;
			return ACC_MIN;
		end
		return s;
	endfunction

	function automatic longint q46_trunc(input longint x);
		return x >= 0 ? (x >>> 30) : -((-x) >>> 30);
	endfunction

	// Sum the series and its derivatives at one grid point
	function automatic series_t eval_series(input logic [15:0] grid);
		logic [63:0] t, k1, k2, k3;
		logic [31:0] phase, ph;
		int idx;
		longint f0, f1, f2, f3, a, b, s, c, u, v, tm;
		bit sat, c2, c3;
		series_t r;
		t = ((64'(grid) << 1) * 64'(step_turns) - 64'(step_turns)) & 64'h1_FFFF_FFFF;
		phase = 32'((t >> 1) + 64'h8000_0000);
		sat = 1'b0;
		f0 = coef_table[0];
		f1 = 0;
		f2 = 0;
		f3 = 0;
		for (int n = 1; n <= harm_count; n++) begin
			ph = 32'(64'(n) * 64'(phase));
			idx = int'(ph >> 22);
			s = sine_lut[idx];
			c = sine_lut[(idx + 256) % SINE_N];
			a = coef_table[2 * n - 1];
			b = coef_table[2 * n];
			u = q46_trunc(a * c - b * s);
			v = q46_trunc(a * s + b * c);
			k1 = 64'(n) * 64'(wavenumber);
			c2 = 1'b0;
			c3 = 1'b0;
			k2 = scale_mul(k1, k1, c2);
			k3 = scale_mul(k2, k1, c3);
			c3 = c3 || c2;
			f0 = sat_add(f0, u, sat);
			tm = scaled(v, k1, 1'b0, sat);
			f1 = sat_add(f1, -tm, sat);
			tm = scaled(u, k2, c2, sat);
			f2 = sat_add(f2, -tm, sat);
			tm = scaled(v, k3, c3, sat);
			f3 = sat_add(f3, tm, sat);
		end
		r.value = f0[47:0];
		r.d1 = f1[47:0];
		r.d2 = f2[47:0];
		r.d3 = f3[47:0];
		r.sat = sat;
		return r;
	endfunction

	// Offer one item, hold it until accepted, then update the predictor
	task automatic send_item(input logic kind, input logic [6:0] slot,
			input logic [31:0] val, input logic [15:0] grid);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {1'b0, grid, val, slot};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_LOAD) begin
			if (slot < SLOTS) coef_table[slot] = longint'($signed(val));
		end else begin
			exp_fifo[exp_wr % EXP_DEPTH] = eval_series(grid);
			exp_wr++;
		end
	endtask

	task automatic load_coef(input int slot, input logic [31:0] val);
		send_item(KIND_LOAD, 7'(slot), val, 16'($urandom));
	endtask

	task automatic eval_at(input logic [15:0] grid);
		send_item(KIND_EVAL, 7'($urandom), $urandom, grid);
	endtask

	// Drop valid and let every expected result drain before touching registers
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] d);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (r)
			CFG_HARMONIC_COUNT: harm_count = d[5:0];
			CFG_PHASE_STEP: step_turns = d;
			CFG_BASE_WAVENUMBER: wavenumber = d;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	// Fill the whole table so that no evaluation reads an unwritten slot
	task automatic test_fill_table();
		for (int i = 0; i < SLOTS; i++) load_coef(i, rand_coef());
	endtask

	// Extremes: no harmonics, full count, limit steps and wavenumbers
	task automatic test_directed();
		eval_at(16'h0000);
		write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_HARMONIC_COUNT, 32'd2);
		load_coef(0, 32'h7FFF_FFFF);
		load_coef(1, 32'h8000_0000);
		load_coef(2, 32'h7FFF_FFFF);
		load_coef(3, 32'h0000_0000);
		load_coef(127, 32'h1234_5678);
		eval_at(16'h0000);
		eval_at(16'hFFFF);
		eval_at(16'h0001);
		write_reg(CFG_BASE_WAVENUMBER, 32'hFFFF_FFFF);
		eval_at(16'h8000);
		eval_at(16'hFFFF);
		write_reg(CFG_BASE_WAVENUMBER, 32'h0000_0000);
		eval_at(16'h1234);
		write_reg(CFG_HARMONIC_COUNT, 32'd63);
		write_reg(CFG_BASE_WAVENUMBER, 32'h0001_0000);
		eval_at(16'h0000);
		eval_at(16'hFFFF);
		write_reg(CFG_BASE_WAVENUMBER, 32'h0100_0000);
		eval_at(16'h5555);
	endtask

	// Random register settings, then a mix of loads and evaluations
	task automatic test_random_phases();
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_HARMONIC_COUNT, (ph == 5) ? 32'd63 : $urandom_range(6));
			write_reg(CFG_PHASE_STEP, $urandom);
			write_reg(CFG_BASE_WAVENUMBER, (ph % 3 == 0) ? $urandom : $urandom_range(1 << 20));
			steady = (ph == 2);
			for (int i = 0; i < ((ph == 5) ? 6 : 50); i++) begin
				if ($urandom_range(99) < 40) load_coef($urandom_range(SLOTS), rand_coef());
				else eval_at(16'($urandom));
			end
			steady = 1'b0;
		end
	endtask

	// Hold the receiver off while items keep coming so the input backs up
	task automatic test_backpressure();
		write_reg(CFG_HARMONIC_COUNT, 32'd1);
		stall_asked++;
		for (int i = 0; i < 20; i++) eval_at(16'($urandom));
	endtask

	// Receiver: random idling, plus a long hold-off on request
	always @(negedge clk) begin
		if (stall_asked != stall_served) begin
			stall_served = stall_asked;
			hold_left = 2000;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 36);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		series_t exp_r;
		if (m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				exp_r = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_tdata[47:0] !== exp_r.value) begin
					$error("field_value exp %0d got %0d", exp_r.value, $signed(m_tdata[47:0]));
					fail_count++;
				end
				if (m_tdata[95:48] !== exp_r.d1) begin
					$error("first_derivative exp %0d got %0d", exp_r.d1,
						$signed(m_tdata[95:48]));
					fail_count++;
				end
				if (m_tdata[143:96] !== exp_r.d2) begin
					$error("second_derivative exp %0d got %0d", exp_r.d2,
						$signed(m_tdata[143:96]));
					fail_count++;
				end
				if (m_tdata[191:144] !== exp_r.d3) begin
					$error("third_derivative exp %0d got %0d", exp_r.d3,
						$signed(m_tdata[191:144]));
					fail_count++;
				end
				if (m_tuser !== exp_r.sat) begin
					$error("saturated exp %0b got %0b", exp_r.sat, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		harm_count = '0;
		step_turns = '0;
		wavenumber = BASE_WAVENUMBER_RESET;
		for (int i = 0; i < SLOTS; i++) coef_table[i] = 0;
		for (int i = 0; i < SINE_N; i++) begin
			if ((i / 256) % 2 == 1) sine_lut[i] = sine_mag(256 - i % 256);
			else sine_lut[i] = sine_mag(i % 256);
			if (i >= 512) sine_lut[i] = -sine_lut[i];
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_fill_table();
		test_directed();
		test_random_phases();
		test_backpressure();
		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
